@@ rtl/core/oli_pkg.sv @@
// oli_pkg: widths, request and status codes shared by the ordered list block
// and its checker. No dependencies.
package oli_pkg;

    localparam int OLI_CAPACITY = 16;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 5;
    localparam int COUNT_W      = 5;
    localparam int ACT_W        = 2;
    localparam int STAT_W       = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

endpackage

@@ rtl/core/oli_ram.sv @@
// oli_ram: generic single write port, single read port RAM with registered
// read data. No package dependencies.
module oli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/ordered_list_insert_delete.sv @@
// Ordered list of up to CAPACITY 32-bit values in a RAM (oli_ram), worked by one
// sequencer that walks the list one entry at a time through a single RAM read
// port. Depends on oli_pkg and oli_ram.
//
// One request is taken at a time; in_stall stays high until its result sits in
// the output register. With count entries held, an insert at index p moves each
// entry from the end down to p up one place, then writes the value (a full list is
// refused); a delete compares entries from index 0 to the first match, then moves
// each later entry down one place; a read waits for the RAM data. Each moved or
// compared entry needs a read state and a write or compare state, as the RAM has
// one registered read port. The list empties at reset without any clearing pass,
// since only entries below the count are ever used. A new request is accepted
// while a result still waits in the output register.
module ordered_list_insert_delete #(
    parameter int CAPACITY = oli_pkg::OLI_CAPACITY
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [oli_pkg::ACT_W-1:0]   action,
    input  logic [oli_pkg::VALUE_W-1:0] value,
    input  logic [oli_pkg::POS_W-1:0]   position,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [oli_pkg::STAT_W-1:0]  status,
    output logic [oli_pkg::COUNT_W-1:0] entry_count,
    output logic [oli_pkg::VALUE_W-1:0] read_value
);
    import oli_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_INS_SH  = 9'b000000010,
        S_INS_WR  = 9'b000000100,
        S_DEL_RD  = 9'b000001000,
        S_DEL_CMP = 9'b000010000,
        S_DEL_SH  = 9'b000100000,
        S_DEL_WR  = 9'b001000000,
        S_RD_WAIT = 9'b010000000,
        S_FIN     = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    status_t            res_st_reg, res_st_next;
    logic [VALUE_W-1:0] res_rd_reg, res_rd_next;

    logic               ov_reg, ov_next;
    status_t            ost_reg, ost_next;
    logic [COUNT_W-1:0] ocnt_reg, ocnt_next;
    logic [VALUE_W-1:0] ord_reg, ord_next;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    logic               accept;
    logic [XW-1:0]      pos_x;
    logic [XW-1:0]      cnt_x;
    logic [CW-1:0]      idx_inc;
    logic [CW-1:0]      idx_dec;

    oli_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign pos_x    = XW'(position);
    assign cnt_x    = XW'(cnt_reg);
    assign idx_inc  = idx_reg + CW'(1);
    assign idx_dec  = idx_reg - CW'(1);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        res_st_next = res_st_reg;
        res_rd_next = res_rd_reg;
        ov_next     = ov_reg && out_stall;
        ost_next    = ost_reg;
        ocnt_next   = ocnt_reg;
        ord_next    = ord_reg;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg[AW-1:0];
        ram_wdata   = ram_rdata;
        ram_raddr   = idx_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    val_next    = value;
                    res_st_next = ST_OK;
                    res_rd_next = '0;
                    unique case (action_t'(action))
                        ACT_INSERT:
                        begin
                            if (cnt_reg >= CW'(CAPACITY))
                            begin
                                res_st_next = ST_FULL;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                idx_next   = cnt_reg;
                                pos_next   = (pos_x >= cnt_x) ? cnt_reg : CW'(position);
                                state_next = S_INS_SH;
                            end
                        end
                        ACT_DELETE:
                        begin
                            idx_next   = '0;
                            state_next = S_DEL_RD;
                        end
                        ACT_READ:
                        begin
                            ram_raddr = AW'(position);
                            if (pos_x < cnt_x)
                            begin
                                state_next = S_RD_WAIT;
                            end
                            else
                            begin
                                res_st_next = ST_RANGE;
                                state_next  = S_FIN;
                            end
                        end
                        ACT_NOP:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_INS_SH:
            begin
                if (idx_reg > pos_reg)
                begin
                    ram_raddr  = idx_dec[AW-1:0];
                    state_next = S_INS_WR;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg[AW-1:0];
                    ram_wdata  = val_reg;
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_FIN;
                end
            end
            S_INS_WR:
            begin
                ram_we     = 1'b1;
                idx_next   = idx_dec;
                state_next = S_INS_SH;
            end
            S_DEL_RD:
            begin
                if (idx_reg < cnt_reg)
                begin
                    state_next = S_DEL_CMP;
                end
                else
                begin
                    res_st_next = ST_NOT_FOUND;
                    state_next  = S_FIN;
                end
            end
            S_DEL_CMP:
            begin
                if (ram_rdata == val_reg)
                begin
                    state_next = S_DEL_SH;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_DEL_RD;
                end
            end
            S_DEL_SH:
            begin
                ram_raddr = idx_inc[AW-1:0];
                if (idx_inc < cnt_reg)
                begin
                    state_next = S_DEL_WR;
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = S_FIN;
                end
            end
            S_DEL_WR:
            begin
                ram_we     = 1'b1;
                idx_next   = idx_inc;
                state_next = S_DEL_SH;
            end
            S_RD_WAIT:
            begin
                res_rd_next = ram_rdata;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    ost_next   = res_st_reg;
                    ocnt_next  = COUNT_W'(cnt_reg);
                    ord_next   = res_rd_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        res_st_reg <= res_st_next;
        res_rd_reg <= res_rd_next;
        ost_reg    <= ost_next;
        ocnt_reg   <= ocnt_next;
        ord_reg    <= ord_next;
    end

    assign out_valid   = ov_reg;
    assign status      = ost_reg;
    assign entry_count = ocnt_reg;
    assign read_value  = ord_reg;

endmodule

@@ rtl/core/oli_checker.sv @@
// oli_checker: port-level assertions for the ordered list block, bound to
// ordered_list_insert_delete. Depends on oli_pkg.
module oli_checker #(
    parameter int CAPACITY = oli_pkg::OLI_CAPACITY
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [oli_pkg::STAT_W-1:0]  status,
    input logic [oli_pkg::COUNT_W-1:0] entry_count,
    input logic [oli_pkg::VALUE_W-1:0] read_value
);
    import oli_pkg::*;

    // busy in the cycle after taking a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block ready right after accepting a request");

    // refused insert only when the list holds its full capacity
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> entry_count == COUNT_W'(CAPACITY))
        else $error("full status with list not at capacity");

    // read data is zero on every failing request
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> read_value == '0)
        else $error("nonzero read data on failing request");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(entry_count) && $stable(read_value))
        else $error("stalled result changed");

endmodule

bind ordered_list_insert_delete oli_checker #(.CAPACITY(CAPACITY)) u_oli_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_count (entry_count),
    .read_value  (read_value)
);
